// File: sv/irpd_pkg.sv
`default_nettype none
package irpd_pkg;

    localparam int NREGS     = 8;
    localparam int IDX_WIDTH = 3;
    localparam int CODE_OUT  = 32;

    typedef enum logic [1:0] {
        OP_EDGE    = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_ACK     = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HDR_MARK  = 3'd1,
        PH_HDR_SPACE = 3'd2,
        PH_BIT_MARK  = 3'd3,
        PH_BIT_SPACE = 3'd4
    } t_phase;

    localparam logic [IDX_WIDTH-1:0] REG_HDR_MARK_MIN  = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_HDR_MARK_MAX  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_HDR_SPACE_MIN = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_HDR_SPACE_MAX = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_SHORT_MIN     = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_BIT_MARK_MAX  = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_BIT_SPACE_MAX = 3'd6;
    localparam logic [IDX_WIDTH-1:0] REG_ONE_THRESH    = 3'd7;

    typedef struct packed {
        logic                frame_done;
        logic [CODE_OUT-1:0] frame_code;
        logic [7:0]          command_byte;
        logic [2:0]          decode_phase;
        logic                expect_rising;
        logic                window_error;
        logic                holding;
    } t_result;

    function automatic logic [31:0] reg_reset_val(input logic [IDX_WIDTH-1:0] idx);
        logic [31:0] v;
        case (idx)
            REG_HDR_MARK_MIN:  v = 32'd8500;
            REG_HDR_MARK_MAX:  v = 32'd9500;
            REG_HDR_SPACE_MIN: v = 32'd4000;
            REG_HDR_SPACE_MAX: v = 32'd5000;
            REG_SHORT_MIN:     v = 32'd400;
            REG_BIT_MARK_MAX:  v = 32'd700;
            REG_BIT_SPACE_MAX: v = 32'd1800;
            default:           v = 32'd1000;
        endcase
        return v;
    endfunction

    // Both bounds exclusive; an inverted or empty window passes nothing.
    function automatic logic win_pass(input logic [31:0] t, input logic [31:0] lo,
                                      input logic [31:0] hi);
        return (t > lo) && (t < hi);
    endfunction

endpackage
`default_nettype wire

// File: sv/irpd_cfg_regs.sv
`default_nettype none
module irpd_cfg_regs #(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_cfg_we,
    input  wire logic [irpd_pkg::IDX_WIDTH-1:0]              i_cfg_index,
    input  wire logic [TIME_WIDTH-1:0]                       i_cfg_data,
    output logic      [irpd_pkg::NREGS-1:0][TIME_WIDTH-1:0]  o_regs
);
    import irpd_pkg::*;

    logic [NREGS-1:0][TIME_WIDTH-1:0] r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREGS; i++) begin
                r_regs[i] <= TIME_WIDTH'(reg_reset_val(IDX_WIDTH'(i)));
            end
        end else if (i_cfg_we) begin
            r_regs[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_regs = r_regs;

endmodule
`default_nettype wire

// File: sv/irpd_decode_fsm.sv
`default_nettype none
module irpd_decode_fsm #(
    parameter int FRAME_BITS = 32,
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_step,
    input  wire logic [1:0]                                  i_opcode,
    input  wire logic [TIME_WIDTH-1:0]                       i_elapsed_us,
    input  wire logic [irpd_pkg::NREGS-1:0][TIME_WIDTH-1:0]  i_regs,
    output irpd_pkg::t_result                                o_result
);
    import irpd_pkg::*;

    localparam int BW = $clog2(FRAME_BITS + 1);

    t_phase                r_phase,  n_phase;
    logic [BW-1:0]         r_bits,   n_bits;
    logic [FRAME_BITS-1:0] r_code,   n_code;
    logic                  r_rising, n_rising;
    logic                  r_held,   n_held;
    logic                  done, err;
    logic [31:0]           t, lo_short;
    logic [BW-1:0]         bits_inc;
    logic [CODE_OUT-1:0]   code_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bits   <= '0;
            r_code   <= '0;
            r_rising <= 1'b0;
            r_held   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_bits   <= n_bits;
            r_code   <= n_code;
            r_rising <= n_rising;
            r_held   <= n_held;
        end
    end

    always_comb begin
        t        = 32'(i_elapsed_us);
        lo_short = 32'(i_regs[REG_SHORT_MIN]);
        bits_inc = r_bits + BW'(1);
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_code   = r_code;
        n_rising = r_rising;
        n_held   = r_held;
        done     = 1'b0;
        err      = 1'b0;
        case (t_opcode'(i_opcode))
            OP_TIMEOUT: begin
                n_phase  = PH_IDLE;
                n_rising = 1'b0;
            end
            OP_ACK: begin
                n_held = 1'b0;
            end
            OP_EDGE: begin
                // Ignore edges while a finished frame waits.
                if (!r_held) begin
                    unique case (r_phase)
                        PH_IDLE: begin
                            n_bits   = '0;
                            n_code   = '0;
                            n_phase  = PH_HDR_MARK;
                            n_rising = 1'b1;
                        end
                        PH_HDR_MARK: begin
                            if (win_pass(t, 32'(i_regs[REG_HDR_MARK_MIN]),
                                         32'(i_regs[REG_HDR_MARK_MAX]))) begin
                                n_phase = PH_HDR_SPACE;
                            end else begin
                                n_phase = PH_IDLE;
                                err     = 1'b1;
                            end
                            n_rising = 1'b0;
                        end
                        PH_HDR_SPACE: begin
                            if (win_pass(t, 32'(i_regs[REG_HDR_SPACE_MIN]),
                                         32'(i_regs[REG_HDR_SPACE_MAX]))) begin
                                n_phase = PH_BIT_MARK;
                            end else begin
                                n_phase = PH_IDLE;
                                err     = 1'b1;
                            end
                            n_rising = 1'b1;
                        end
                        PH_BIT_MARK: begin
                            if (win_pass(t, lo_short, 32'(i_regs[REG_BIT_MARK_MAX]))) begin
                                n_phase = PH_BIT_SPACE;
                            end else begin
                                n_phase = PH_IDLE;
                                err     = 1'b1;
                            end
                            n_rising = 1'b0;
                        end
                        PH_BIT_SPACE: begin
                            if (win_pass(t, lo_short, 32'(i_regs[REG_BIT_SPACE_MAX]))) begin
                                n_code = {r_code[FRAME_BITS-2:0],
                                          (t > 32'(i_regs[REG_ONE_THRESH]))};
                                n_bits = bits_inc;
                                if (bits_inc >= BW'(FRAME_BITS)) begin
                                    done    = 1'b1;
                                    n_held  = 1'b1;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_phase = PH_BIT_MARK;
                                end
                            end else begin
                                n_phase = PH_IDLE;
                                err     = 1'b1;
                            end
                            n_rising = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign code_out = CODE_OUT'(n_code);

    always_comb begin
        o_result.frame_done    = done;
        o_result.frame_code    = code_out;
        o_result.command_byte  = code_out[15:8];
        o_result.decode_phase  = n_phase;
        o_result.expect_rising = n_rising;
        o_result.window_error  = err;
        o_result.holding       = n_held;
    end

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && done) |=> (r_held && r_phase == PH_IDLE))
        else $error("completed frame not held");

    a_held_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_held && t_opcode'(i_opcode) == OP_EDGE)
        |=> ($stable(r_code) && $stable(r_phase) && $stable(r_bits)))
        else $error("edge changed state while holding");

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BW'(FRAME_BITS))
        else $error("bit count beyond frame length");

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && err) |=> (r_phase == PH_IDLE && !r_held))
        else $error("window failure did not restart");

endmodule
`default_nettype wire

// File: sv/irpd_out_reg.sv
`default_nettype none
module irpd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_step,
    input  irpd_pkg::t_result      i_result,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output irpd_pkg::t_result      o_result
);
    import irpd_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    step;

    // Take a new beat when the register is empty or the held result leaves in the same cycle.
    assign o_stall = r_valid && i_stall;
    assign step    = i_valid && !o_stall;
    assign o_step  = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// File: sv/ir_pulse_distance_decoder_core.sv
`default_nettype none
// Pulse-distance infrared frame decoder. Each input beat is an edge (with the
// microseconds since the previous edge), a timer timeout or an acknowledge,
// and it yields exactly one result beat in the next cycle: phase, expected
// edge direction, window error, hold flag and the shift register with its
// command byte, plus frame_done on the beat that completes a frame. A beat can
// be taken every cycle, also while the previous result is being taken, unless a
// held result stalls; window compare and next-state logic are combinational
// between state and result registers. The user must write the eight window
// registers via the config port only while idle; the block does not enforce it.
module ir_pulse_distance_decoder_core #(
    parameter int FRAME_BITS = 32,
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic [TIME_WIDTH-1:0]          i_elapsed_us,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_frame_done,
    output logic [31:0]                         o_frame_code,
    output logic [7:0]                          o_command_byte,
    output logic [2:0]                          o_decode_phase,
    output logic                                o_expect_rising,
    output logic                                o_window_error,
    output logic                                o_holding,
    input  wire logic                           i_cfg_we,
    input  wire logic [irpd_pkg::IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [TIME_WIDTH-1:0]          i_cfg_data
);
    import irpd_pkg::*;

    logic [NREGS-1:0][TIME_WIDTH-1:0] regs;
    logic                             step;
    t_result                          next_res;
    t_result                          out_res;

    irpd_cfg_regs #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_regs      (regs)
    );

    irpd_decode_fsm #(
        .FRAME_BITS (FRAME_BITS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_opcode     (i_opcode),
        .i_elapsed_us (i_elapsed_us),
        .i_regs       (regs),
        .o_result     (next_res)
    );

    irpd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_step   (step),
        .i_result (next_res),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_res)
    );

    assign o_frame_done    = out_res.frame_done;
    assign o_frame_code    = out_res.frame_code;
    assign o_command_byte  = out_res.command_byte;
    assign o_decode_phase  = out_res.decode_phase;
    assign o_expect_rising = out_res.expect_rising;
    assign o_window_error  = out_res.window_error;
    assign o_holding       = out_res.holding;

endmodule
`default_nettype wire
